// ===== sv/dpr_pkg.sv =====
// ----------------------------------------------------------------------------
// dpr_pkg: shared types, codes and microcode program of the demand pager
// Holds the control word layout, the sequencer program and small helpers
// used by the sequencer and the pager datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dpr_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_PEND  = 2'd0,
    KIND_DIRTY = 2'd1,
    KIND_SERVE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Result outcomes
  typedef enum logic [1:0] {
    OUT_MARK    = 2'd0,
    OUT_FREE    = 2'd1,
    OUT_REPLACE = 2'd2,
    OUT_NONE    = 2'd3
  } outcome_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUM_PAGES  = 2'd0;
  localparam logic [1:0] CFG_NUM_FRAMES = 2'd1;
  localparam logic [1:0] CFG_SEED       = 2'd2;

  localparam logic [7:0]  RESET_NUM_PAGES  = 8'd128;
  localparam logic [7:0]  RESET_NUM_FRAMES = 8'd8;
  localparam logic [15:0] RESET_SEED       = 16'd44257;
  localparam logic [15:0] LFSR_TAPS        = 16'hB400;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

  // Datapath actions, one per control word
  typedef enum logic [4:0] {
    A_NOP,
    A_CLEAR,
    A_ACCEPT,
    A_MARK_RD,
    A_MARK_WR,
    A_SCAN_INIT,
    A_SCAN_PT,
    A_SCAN_FT,
    A_NONE,
    A_LFSR,
    A_MOD,
    A_OWN_RD,
    A_OWN_CHK,
    A_EVICT,
    A_TAKE,
    A_LOAD,
    A_EMIT
  } act_t;

  // Next-step conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_IN,
    C_SERVE,
    C_SCAN,
    C_CLR,
    C_MOD,
    C_OUT
  } cond_t;

  // Program steps
  typedef enum logic [4:0] {
    S_CLR     = 5'd0,
    S_IDLE    = 5'd1,
    S_DISP    = 5'd2,
    S_MARK_RD = 5'd3,
    S_MARK_WR = 5'd4,
    S_PT_INIT = 5'd5,
    S_PT_SCAN = 5'd6,
    S_NONE    = 5'd7,
    S_FT_INIT = 5'd8,
    S_FT_SCAN = 5'd9,
    S_RAND    = 5'd10,
    S_MOD     = 5'd11,
    S_OWN_RD  = 5'd12,
    S_OWN_CHK = 5'd13,
    S_EVICT   = 5'd14,
    S_TAKE    = 5'd15,
    S_LOAD    = 5'd16,
    S_EMIT    = 5'd17
  } step_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } ctl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_acc;
    logic serve;
    logic scan_hit;
    logic scan_done;
    logic clr_last;
    logic mod_last;
    logic out_free;
  } seq_flags_t;

  // Microcode program
  function automatic ctl_t program_word(input step_t step);
    ctl_t w;
    unique case (step)
      S_CLR:     w = '{A_CLEAR,     C_CLR,   S_IDLE};
      S_IDLE:    w = '{A_ACCEPT,    C_IN,    S_IDLE};
      S_DISP:    w = '{A_NOP,       C_SERVE, S_PT_INIT};
      S_MARK_RD: w = '{A_MARK_RD,   C_NEXT,  S_IDLE};
      S_MARK_WR: w = '{A_MARK_WR,   C_JUMP,  S_EMIT};
      S_PT_INIT: w = '{A_SCAN_INIT, C_NEXT,  S_IDLE};
      S_PT_SCAN: w = '{A_SCAN_PT,   C_SCAN,  S_FT_INIT};
      S_NONE:    w = '{A_NONE,      C_JUMP,  S_EMIT};
      S_FT_INIT: w = '{A_SCAN_INIT, C_NEXT,  S_IDLE};
      S_FT_SCAN: w = '{A_SCAN_FT,   C_SCAN,  S_TAKE};
      S_RAND:    w = '{A_LFSR,      C_NEXT,  S_IDLE};
      S_MOD:     w = '{A_MOD,       C_MOD,   S_IDLE};
      S_OWN_RD:  w = '{A_OWN_RD,    C_NEXT,  S_IDLE};
      S_OWN_CHK: w = '{A_OWN_CHK,   C_NEXT,  S_IDLE};
      S_EVICT:   w = '{A_EVICT,     C_JUMP,  S_LOAD};
      S_TAKE:    w = '{A_TAKE,      C_NEXT,  S_IDLE};
      S_LOAD:    w = '{A_LOAD,      C_NEXT,  S_IDLE};
      S_EMIT:    w = '{A_EMIT,      C_OUT,   S_IDLE};
      default:   w = '{A_NOP,       C_JUMP,  S_IDLE};
    endcase
    return w;
  endfunction

  // Galois LFSR, right shift
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = {1'b0, v[15:1]};
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dpr_ram.sv =====
// ----------------------------------------------------------------------------
// dpr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/dpr_seq.sv =====
// ----------------------------------------------------------------------------
// dpr_seq: microcode sequencer of the demand pager
// Holds the step counter, fetches the control word and picks the next step.
// ----------------------------------------------------------------------------
`default_nettype none

module dpr_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dpr_pkg::seq_flags_t flags,
  output dpr_pkg::ctl_t            ctl
);

  import dpr_pkg::*;

  step_t pc_r;
  step_t pc_nxt;

  assign ctl = program_word(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    unique case (ctl.cond)
      C_NEXT:  pc_nxt = step_t'(pc_r + 5'd1);
      C_JUMP:  pc_nxt = ctl.target;
      C_IN:    if (flags.in_acc) begin
        pc_nxt = step_t'(pc_r + 5'd1);
      end
      C_SERVE: pc_nxt = flags.serve ? ctl.target : step_t'(pc_r + 5'd1);
      C_SCAN:  begin
        if (flags.scan_hit) begin
          pc_nxt = ctl.target;
        end else if (flags.scan_done) begin
          pc_nxt = step_t'(pc_r + 5'd1);
        end
      end
      C_CLR:   if (flags.clr_last) begin
        pc_nxt = step_t'(pc_r + 5'd1);
      end
      C_MOD:   if (flags.mod_last) begin
        pc_nxt = step_t'(pc_r + 5'd1);
      end
      C_OUT:   if (flags.out_free) begin
        pc_nxt = ctl.target;
      end
      default: pc_nxt = S_IDLE;
    endcase
  end

  // advance the step counter; reset starts the table clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_CLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/demand_pager_random_replace_top.sv =====
// ----------------------------------------------------------------------------
// demand_pager_random_replace_top: demand pager with random replacement
// Page table and frame owner table in RAM, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  cfg     | in        | cfg_we               | cfg_index, cfg_wdata
//  in      | in        | in_tvalid/in_tready  | in_tuser kind, in_tdata page/req
//  out     | out       | out_tvalid/out_tready| out_tuser outcome, out_tdata
//
//  Path from the input transfer to out_tvalid: a mark item (kind 0, 1, 3) reads
//  and rewrites its page table entry; a service scans the page table for the
//  lowest pending page (none found ends it), then the frame table for a free
//  frame f to load page p into, else replaces: the LFSR steps and a serial
//  modulo of the LFSR by the frame count picks the frame. After the result is
//  loaded the sequencer returns to idle to take the next input. The page table
//  scan and the free frame scan read one RAM entry a cycle. Reset: a clearing
//  pass writes every page table and frame table entry, one per cycle, first.
//  Stalls: a finished result waits in the output register; the next input is
//  taken meanwhile and its result is held back until the register frees.
//
`default_nettype none

module demand_pager_random_replace_top #(
  parameter int MAX_PAGE_COUNT = 128,
  parameter int REQUESTER_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [6:0] page, [22:7] requester, [23] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [6:0] loaded_page, [13:7] frame, [20:14] evicted_page, [21] wrote_back,
  // [37:22] resume_requester, [69:38] access_total, [71:70] zero
  output logic      [71:0] out_tdata,
  output logic      [1:0]  out_tuser   // [1:0] outcome
);

  import dpr_pkg::*;

  localparam int PW  = $clog2(MAX_PAGE_COUNT);   // page / frame index bits
  localparam int LW  = PW + 1;                   // holds a count up to the max
  localparam int XW  = (LW > 8) ? LW : 8;        // compare width vs 8-bit regs
  localparam int RB  = REQUESTER_BITS;
  localparam int PTW = 2 + PW + RB;              // {valid, dirty, frame, pend}
  localparam int FTW = 1 + PW;                   // {owned, page}

  // width adapters for the fixed 7-bit and 16-bit fields
  function automatic logic [PW-1:0] from7(input logic [6:0] v);
    logic [PW+6:0] t;
    t = {{PW{1'b0}}, v};
    return t[PW-1:0];
  endfunction

  function automatic logic [6:0] to7(input logic [PW-1:0] v);
    logic [PW+6:0] t;
    t = {7'd0, v};
    return t[6:0];
  endfunction

  function automatic logic [RB-1:0] from16(input logic [15:0] v);
    logic [RB+15:0] t;
    t = {{RB{1'b0}}, v};
    return t[RB-1:0];
  endfunction

  function automatic logic [15:0] to16(input logic [RB-1:0] v);
    logic [RB+15:0] t;
    t = {16'd0, v};
    return t[15:0];
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  ctl_t       ctl;
  seq_flags_t flags;

  dpr_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  // --------------------------------------------------------------------------
  // Tables
  // --------------------------------------------------------------------------
  logic           pt_we, pt_re;
  logic [PW-1:0]  pt_waddr, pt_raddr;
  logic [PTW-1:0] pt_wdata, pt_rdata;
  logic           ft_we, ft_re;
  logic [PW-1:0]  ft_waddr, ft_raddr;
  logic [FTW-1:0] ft_wdata, ft_rdata;

  dpr_ram #(.WIDTH(PTW), .DEPTH(MAX_PAGE_COUNT)) u_page_tbl (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  dpr_ram #(.WIDTH(FTW), .DEPTH(MAX_PAGE_COUNT)) u_frame_tbl (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ft_waddr),
    .wdata (ft_wdata),
    .re    (ft_re),
    .raddr (ft_raddr),
    .rdata (ft_rdata)
  );

  // page table word fields
  logic [RB-1:0] pt_pend;
  logic [PW-1:0] pt_frame;
  logic          pt_dirty, pt_valid;
  assign pt_pend  = pt_rdata[RB-1:0];
  assign pt_frame = pt_rdata[RB+PW-1:RB];
  assign pt_dirty = pt_rdata[RB+PW];
  assign pt_valid = pt_rdata[RB+PW+1];

  logic          ft_owned;
  logic [PW-1:0] ft_page;
  assign ft_page  = ft_rdata[PW-1:0];
  assign ft_owned = ft_rdata[PW];

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [7:0]    num_pages_r,  num_pages_nxt;
  logic [7:0]    num_frames_r, num_frames_nxt;
  logic [15:0]   lfsr_r,       lfsr_nxt;
  logic [31:0]   count_r,      count_nxt;
  logic [LW-1:0] idx_r,        idx_nxt;
  logic          last_v_r,     last_v_nxt;
  logic [PW-1:0] last_idx_r,   last_idx_nxt;
  kind_t         kind_r,       kind_nxt;
  logic [6:0]    pg7_r,        pg7_nxt;
  logic [PW-1:0] page_r,       page_nxt;
  logic [RB-1:0] req_r,        req_nxt;
  logic [PW-1:0] frame_r,      frame_nxt;
  logic [PW-1:0] victim_r,     victim_nxt;
  logic          vict_v_r,     vict_v_nxt;
  logic          wb_r,         wb_nxt;
  outcome_t      outcome_r,    outcome_nxt;
  logic [LW-1:0] rem_r,        rem_nxt;
  logic [3:0]    bit_r,        bit_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;
  logic [71:0]   out_tdata_r,  out_tdata_nxt;
  logic [1:0]    out_tuser_r,  out_tuser_nxt;

  // --------------------------------------------------------------------------
  // Derived limits and status
  // --------------------------------------------------------------------------
  logic [LW-1:0] npages, nframes, scan_limit;
  logic          in_rng, scan_test, page_ok, out_free, in_acc;
  logic [LW:0]   mod_sh, mod_sub;
  logic [LW-1:0] mod_rem;
  logic          show_load, show_evict;

  // clamp page count to the table depth; zero frames act as one
  assign npages = (XW'(num_pages_r) > XW'(MAX_PAGE_COUNT)) ? LW'(MAX_PAGE_COUNT)
                                                         : LW'(num_pages_r);
  always_comb begin
    if (num_frames_r == 8'd0) begin
      nframes = LW'(1);
    end else if (XW'(num_frames_r) > XW'(MAX_PAGE_COUNT)) begin
      nframes = LW'(MAX_PAGE_COUNT);
    end else begin
      nframes = LW'(num_frames_r);
    end
  end

  // shared scan: a read is issued at idx while the previous one is checked
  assign scan_limit = (ctl.act == A_SCAN_FT) ? nframes : npages;
  assign scan_test  = (ctl.act == A_SCAN_FT) ? !ft_owned : (pt_pend != '0);
  assign in_rng     = idx_r < scan_limit;

  assign page_ok  = XW'(pg7_r) < XW'(npages);
  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (ctl.act == A_ACCEPT);
  assign in_acc    = in_tvalid && in_tready;

  // one restoring step of lfsr modulo frame count, MSB first
  assign mod_sh  = {rem_r, lfsr_r[4'd15 - bit_r]};
  assign mod_sub = mod_sh - {1'b0, nframes};
  assign mod_rem = (mod_sh >= {1'b0, nframes}) ? mod_sub[LW-1:0] : mod_sh[LW-1:0];

  assign show_load  = (outcome_r == OUT_FREE) || (outcome_r == OUT_REPLACE);
  assign show_evict = (outcome_r == OUT_REPLACE);

  always_comb begin
    flags.in_acc    = in_acc;
    flags.serve     = (kind_r == KIND_SERVE);
    flags.scan_hit  = last_v_r && scan_test;
    flags.scan_done = !last_v_r && !in_rng;
    flags.clr_last  = (idx_r == LW'(MAX_PAGE_COUNT - 1));
    flags.mod_last  = (bit_r == 4'd15);
    flags.out_free  = out_free;
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_comb begin
    num_pages_nxt  = num_pages_r;
    num_frames_nxt = num_frames_r;
    lfsr_nxt       = lfsr_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    last_v_nxt     = last_v_r;
    last_idx_nxt   = last_idx_r;
    kind_nxt       = kind_r;
    pg7_nxt        = pg7_r;
    page_nxt       = page_r;
    req_nxt        = req_r;
    frame_nxt      = frame_r;
    victim_nxt     = victim_r;
    vict_v_nxt     = vict_v_r;
    wb_nxt         = wb_r;
    outcome_nxt    = outcome_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    pt_we    = 1'b0;
    pt_waddr = '0;
    pt_wdata = '0;
    pt_re    = 1'b0;
    pt_raddr = '0;
    ft_we    = 1'b0;
    ft_waddr = '0;
    ft_wdata = '0;
    ft_re    = 1'b0;
    ft_raddr = '0;

    // drop the held result once it transfers
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (ctl.act)
      A_NOP: begin
      end
      A_CLEAR: begin
        // zero page entries, mark every frame unowned (free)
        pt_we    = 1'b1;
        pt_waddr = idx_r[PW-1:0];
        ft_we    = 1'b1;
        ft_waddr = idx_r[PW-1:0];
        idx_nxt  = idx_r + LW'(1);
      end
      A_ACCEPT: begin
        if (in_acc) begin
          kind_nxt = kind_t'(in_tuser);
          pg7_nxt  = in_tdata[6:0];
          page_nxt = from7(in_tdata[6:0]);
          req_nxt  = from16(in_tdata[22:7]);
        end
      end
      A_MARK_RD: begin
        pt_re    = 1'b1;
        pt_raddr = page_r;
      end
      A_MARK_WR: begin
        outcome_nxt = OUT_MARK;
        pt_waddr    = page_r;
        if (page_ok && (kind_r == KIND_PEND) && !pt_valid) begin
          pt_we    = 1'b1;
          pt_wdata = {pt_valid, pt_dirty, pt_frame, req_r};
        end else if (page_ok && (kind_r == KIND_DIRTY) && pt_valid) begin
          pt_we    = 1'b1;
          pt_wdata = {pt_valid, 1'b1, pt_frame, pt_pend};
        end
      end
      A_SCAN_INIT: begin
        idx_nxt    = '0;
        last_v_nxt = 1'b0;
      end
      A_SCAN_PT: begin
        pt_re        = in_rng;
        pt_raddr     = idx_r[PW-1:0];
        last_v_nxt   = in_rng;
        last_idx_nxt = idx_r[PW-1:0];
        if (in_rng) begin
          idx_nxt = idx_r + LW'(1);
        end
        // hold the lowest pending page and its requester
        if (flags.scan_hit) begin
          page_nxt = last_idx_r;
          req_nxt  = pt_pend;
        end
      end
      A_SCAN_FT: begin
        ft_re        = in_rng;
        ft_raddr     = idx_r[PW-1:0];
        last_v_nxt   = in_rng;
        last_idx_nxt = idx_r[PW-1:0];
        if (in_rng) begin
          idx_nxt = idx_r + LW'(1);
        end
        if (flags.scan_hit) begin
          frame_nxt = last_idx_r;
        end
      end
      A_NONE: begin
        outcome_nxt = OUT_NONE;
      end
      A_LFSR: begin
        lfsr_nxt = lfsr_step(lfsr_r);
        rem_nxt  = '0;
        bit_nxt  = '0;
      end
      A_MOD: begin
        rem_nxt   = mod_rem;
        frame_nxt = mod_rem[PW-1:0];
        bit_nxt   = bit_r + 4'd1;
      end
      A_OWN_RD: begin
        ft_re    = 1'b1;
        ft_raddr = frame_r;
      end
      A_OWN_CHK: begin
        vict_v_nxt = ft_owned;
        victim_nxt = ft_owned ? ft_page : '0;
        pt_re      = 1'b1;
        pt_raddr   = ft_page;
      end
      A_EVICT: begin
        outcome_nxt = OUT_REPLACE;
        wb_nxt      = vict_v_r && pt_dirty;
        if (vict_v_r) begin
          pt_we    = 1'b1;
          pt_waddr = victim_r;
          pt_wdata = '0;
          if (pt_dirty) begin
            count_nxt = sat_inc(count_r);
          end
        end
      end
      A_TAKE: begin
        outcome_nxt = OUT_FREE;
        victim_nxt  = '0;
        wb_nxt      = 1'b0;
      end
      A_LOAD: begin
        pt_we     = 1'b1;
        pt_waddr  = page_r;
        pt_wdata  = {1'b1, 1'b0, frame_r, {RB{1'b0}}};
        ft_we     = 1'b1;
        ft_waddr  = frame_r;
        ft_wdata  = {1'b1, page_r};
        count_nxt = sat_inc(count_r);
      end
      A_EMIT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = outcome_r;
          out_tdata_nxt  = {2'b00,
                            count_r,
                            show_load  ? to16(req_r)   : 16'd0,
                            show_evict ? wb_r          : 1'b0,
                            show_evict ? to7(victim_r) : 7'd0,
                            show_load  ? to7(frame_r)  : 7'd0,
                            show_load  ? to7(page_r)   : 7'd0};
        end
      end
      default: begin
      end
    endcase

    // configuration writes must arrive only while idle; the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_PAGES:  num_pages_nxt  = cfg_wdata[7:0];
        CFG_NUM_FRAMES: num_frames_nxt = cfg_wdata[7:0];
        CFG_SEED:       lfsr_nxt       = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pages_r  <= RESET_NUM_PAGES;
      num_frames_r <= RESET_NUM_FRAMES;
      lfsr_r       <= RESET_SEED;
      count_r      <= '0;
      idx_r        <= '0;
      last_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      num_pages_r  <= num_pages_nxt;
      num_frames_r <= num_frames_nxt;
      lfsr_r       <= lfsr_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      last_v_r     <= last_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    last_idx_r  <= last_idx_nxt;
    kind_r      <= kind_nxt;
    pg7_r       <= pg7_nxt;
    page_r      <= page_nxt;
    req_r       <= req_nxt;
    frame_r     <= frame_nxt;
    victim_r    <= victim_nxt;
    vict_v_r    <= vict_v_nxt;
    wb_r        <= wb_nxt;
    outcome_r   <= outcome_nxt;
    rem_r       <= rem_nxt;
    bit_r       <= bit_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // an accepted item leaves the idle step at once
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input ready held after a transfer");

  // a result is loaded whenever the emit step finds the register free
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.act == A_EMIT && out_free) |=> out_tvalid)
    else $error("emit step did not load the result");

  // the frame being loaded lies below the active frame count
  a_frame_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.act == A_LOAD) |-> (LW'(frame_r) < nframes))
    else $error("load into a frame outside the frame count");

  // the disk access count never goes down
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r >= $past(count_r)))
    else $error("disk access count decreased");

endmodule

`default_nettype wire
